// ===== sv/lbpu_pkg.sv =====
// Package for the lossless bitmap pixel unpacker.
// Shared types, reset constants and codes; no dependencies.
package lbpu_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd0;
  localparam logic [2:0] REG_ALPHA_PRESENT = 3'd1;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd2;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_PALETTE_LAST  = 3'd4;

  // Pixel format codes
  localparam logic [1:0] FMT_COLORMAP = 2'd0;
  localparam logic [1:0] FMT_RGB15    = 2'd1;
  localparam logic [1:0] FMT_RGB24    = 2'd2;
  localparam logic [1:0] FMT_UNUSED   = 2'd3;

  // Output item kinds
  localparam logic [1:0] KIND_PALETTE = 2'd0;
  localparam logic [1:0] KIND_INDEX   = 2'd1;
  localparam logic [1:0] KIND_DIRECT  = 2'd2;

  // Register reset values
  localparam logic [1:0]  RST_PIXEL_FORMAT  = FMT_RGB24;
  localparam logic        RST_ALPHA_PRESENT = 1'b0;
  localparam logic [15:0] RST_IMAGE_WIDTH   = 16'd1;
  localparam logic [15:0] RST_IMAGE_HEIGHT  = 16'd1;
  localparam logic [7:0]  RST_PALETTE_LAST  = 8'd0;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Byte-parser phase, one-hot
  typedef enum logic [3:0] {
    PH_PALETTE = 4'b0001,
    PH_PIXELS  = 4'b0010,
    PH_PAD     = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  // Layout of the collected bytes in a request
  typedef enum logic [2:0] {
    IT_PAL3  = 3'd0,
    IT_PAL4  = 3'd1,
    IT_INDEX = 3'd2,
    IT_RGB15 = 3'd3,
    IT_RGB24 = 3'd4,
    IT_ARGB  = 3'd5
  } item_type_t;

  // One classified request from front to back
  typedef struct packed {
    item_type_t  itype;
    logic [31:0] bytes;      // item bytes, last received in the low byte
    logic [7:0]  pal_index;  // palette entry number
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } rec_t;

endpackage

// ===== sv/lossless_bitmap_pixel_unpacker.sv =====
// Lossless bitmap pixel unpacker, top level. Depends on lbpu_pkg and the
// lbpu_front, lbpu_queue and lbpu_back modules.
// Path: the front pushes a completed item into the queue; the back loads it
//   into the output register once that register is free.
// Throughput: one byte per cycle while the queue has room, set by the parser.
// Reset: synchronous rst restores register defaults (RGB24, 1x1, no alpha).
module lossless_bitmap_pixel_unpacker #(
  parameter int QUEUE_DEPTH = lbpu_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // entry_index, red, green, blue, alpha, pixel_x, pixel_y (from bit 0 up)
  output logic [71:0] m_tdata,
  output logic [1:0]  m_tuser,   // item_kind
  output logic        m_tlast    // last_pixel
);

  logic           q_full;
  logic           push;
  lbpu_pkg::rec_t push_rec;
  logic           pop;
  logic           q_not_empty;
  lbpu_pkg::rec_t q_head;
  logic [7:0]     entry_index, red, green, blue, alpha;
  logic [15:0]    pixel_x, pixel_y;

  assign s_tready = !q_full;

  // Byte parser
  lbpu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid && s_tready),
    .in_byte   (s_tdata),
    .push      (push),
    .push_rec  (push_rec)
  );

  // Request queue
  lbpu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Result formatter and output register
  lbpu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .item_kind   (m_tuser),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .last_pixel  (m_tlast)
  );

  assign m_tdata = {pixel_y, pixel_x, alpha, blue, green, red, entry_index};

endmodule

// ===== sv/lbpu_front.sv =====
// Front of the unpacker: configuration registers and the byte parser.
// Collects bytes into items, swallows row padding, pushes rec_t requests.
// Depends on lbpu_pkg.
module lbpu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                push,
  output lbpu_pkg::rec_t      push_rec
);

  // Configuration registers
  logic [1:0]  pixel_format, pixel_format_next;
  logic        alpha_present, alpha_present_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic [7:0]  palette_last, palette_last_next;
  logic        restart;

  // Parser state
  lbpu_pkg::phase_t phase, phase_next;
  logic [1:0]  byte_in_item, byte_in_item_next;
  logic [23:0] held_bytes, held_bytes_next;
  logic [7:0]  palette_counter, palette_counter_next;
  logic [15:0] column, column_next;
  logic [15:0] row, row_next;
  logic [1:0]  row_bytes_mod4, row_bytes_mod4_next;
  logic [1:0]  pad_remaining, pad_remaining_next;

  logic [1:0]  last_byte;      // byte_in_item value that completes an item
  logic [1:0]  rbm_inc;
  logic [1:0]  pad;
  logic [16:0] col_plus1;
  logic [16:0] row_plus1;
  logic        row_end;
  logic        img_end;
  logic        pix_ok;

  // Register writes; any known index restarts the stream
  always_comb begin
    pixel_format_next  = pixel_format;
    alpha_present_next = alpha_present;
    image_width_next   = image_width;
    image_height_next  = image_height;
    palette_last_next  = palette_last;
    restart            = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        lbpu_pkg::REG_PIXEL_FORMAT: begin
          pixel_format_next = cfg_data[1:0];
          restart = 1'b1;
        end
        lbpu_pkg::REG_ALPHA_PRESENT: begin
          alpha_present_next = cfg_data[0];
          restart = 1'b1;
        end
        lbpu_pkg::REG_IMAGE_WIDTH: begin
          image_width_next = cfg_data;
          restart = 1'b1;
        end
        lbpu_pkg::REG_IMAGE_HEIGHT: begin
          image_height_next = cfg_data;
          restart = 1'b1;
        end
        lbpu_pkg::REG_PALETTE_LAST: begin
          palette_last_next = cfg_data[7:0];
          restart = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  // Shared position arithmetic
  assign col_plus1 = {1'b0, column} + 17'd1;
  assign row_plus1 = {1'b0, row} + 17'd1;
  assign row_end   = col_plus1 >= {1'b0, image_width};
  assign img_end   = (col_plus1 == {1'b0, image_width}) &&
                     (row_plus1 == {1'b0, image_height});
  assign rbm_inc   = row_bytes_mod4 + 2'd1;
  assign pad       = 2'd0 - rbm_inc;
  assign pix_ok    = (pixel_format_next != lbpu_pkg::FMT_UNUSED) &&
                     (image_width_next != 16'd0) &&
                     (image_height_next != 16'd0);

  // Completing byte index of the current item
  always_comb begin
    if (phase == lbpu_pkg::PH_PALETTE) begin
      last_byte = alpha_present ? 2'd3 : 2'd2;
    end else begin
      case (pixel_format)
        lbpu_pkg::FMT_COLORMAP: last_byte = 2'd0;
        lbpu_pkg::FMT_RGB15:    last_byte = 2'd1;
        default:                last_byte = alpha_present ? 2'd3 : 2'd2;
      endcase
    end
  end

  // Parser next state and request build
  always_comb begin
    phase_next           = phase;
    byte_in_item_next    = byte_in_item;
    held_bytes_next      = held_bytes;
    palette_counter_next = palette_counter;
    column_next          = column;
    row_next             = row;
    row_bytes_mod4_next  = row_bytes_mod4;
    pad_remaining_next   = pad_remaining;
    push                 = 1'b0;
    push_rec.itype       = lbpu_pkg::IT_RGB24;
    push_rec.bytes       = {held_bytes, in_byte};
    push_rec.pal_index   = palette_counter;
    push_rec.x           = column;
    push_rec.y           = row;
    push_rec.last        = img_end;

    if (restart) begin
      byte_in_item_next    = 2'd0;
      held_bytes_next      = 24'd0;
      palette_counter_next = 8'd0;
      column_next          = 16'd0;
      row_next             = 16'd0;
      row_bytes_mod4_next  = 2'd0;
      pad_remaining_next   = 2'd0;
      if (pixel_format_next == lbpu_pkg::FMT_COLORMAP) begin
        phase_next = lbpu_pkg::PH_PALETTE;
      end else if (pix_ok) begin
        phase_next = lbpu_pkg::PH_PIXELS;
      end else begin
        phase_next = lbpu_pkg::PH_DONE;
      end
    end else if (in_valid) begin
      case (phase)
        lbpu_pkg::PH_PALETTE: begin
          if (byte_in_item != last_byte) begin
            held_bytes_next   = {held_bytes[15:0], in_byte};
            byte_in_item_next = byte_in_item + 2'd1;
          end else begin
            push              = 1'b1;
            push_rec.itype    = alpha_present ? lbpu_pkg::IT_PAL4 : lbpu_pkg::IT_PAL3;
            push_rec.x        = 16'd0;
            push_rec.y        = 16'd0;
            push_rec.last     = 1'b0;
            byte_in_item_next = 2'd0;
            held_bytes_next   = 24'd0;
            if (palette_counter == palette_last) begin
              palette_counter_next = 8'd0;
              phase_next = pix_ok ? lbpu_pkg::PH_PIXELS : lbpu_pkg::PH_DONE;
            end else begin
              palette_counter_next = palette_counter + 8'd1;
            end
          end
        end
        lbpu_pkg::PH_PIXELS: begin
          row_bytes_mod4_next = rbm_inc;
          if (byte_in_item != last_byte) begin
            held_bytes_next   = {held_bytes[15:0], in_byte};
            byte_in_item_next = byte_in_item + 2'd1;
          end else begin
            push = 1'b1;
            case (pixel_format)
              lbpu_pkg::FMT_COLORMAP: push_rec.itype = lbpu_pkg::IT_INDEX;
              lbpu_pkg::FMT_RGB15:    push_rec.itype = lbpu_pkg::IT_RGB15;
              default: push_rec.itype = alpha_present ? lbpu_pkg::IT_ARGB
                                                      : lbpu_pkg::IT_RGB24;
            endcase
            byte_in_item_next = 2'd0;
            held_bytes_next   = 24'd0;
            if (row_end) begin
              column_next         = 16'd0;
              row_bytes_mod4_next = 2'd0;
              if (pad != 2'd0) begin
                pad_remaining_next = pad;
                phase_next         = lbpu_pkg::PH_PAD;
              end else if (row_plus1 >= {1'b0, image_height}) begin
                phase_next = lbpu_pkg::PH_DONE;
              end else begin
                row_next = row_plus1[15:0];
              end
            end else begin
              column_next = col_plus1[15:0];
            end
          end
        end
        lbpu_pkg::PH_PAD: begin
          pad_remaining_next = pad_remaining - 2'd1;
          if (pad_remaining == 2'd1) begin
            if (row_plus1 >= {1'b0, image_height}) begin
              phase_next = lbpu_pkg::PH_DONE;
            end else begin
              row_next   = row_plus1[15:0];
              phase_next = lbpu_pkg::PH_PIXELS;
            end
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format    <= lbpu_pkg::RST_PIXEL_FORMAT;
      alpha_present   <= lbpu_pkg::RST_ALPHA_PRESENT;
      image_width     <= lbpu_pkg::RST_IMAGE_WIDTH;
      image_height    <= lbpu_pkg::RST_IMAGE_HEIGHT;
      palette_last    <= lbpu_pkg::RST_PALETTE_LAST;
      phase           <= lbpu_pkg::PH_PIXELS;
      byte_in_item    <= 2'd0;
      held_bytes      <= 24'd0;
      palette_counter <= 8'd0;
      column          <= 16'd0;
      row             <= 16'd0;
      row_bytes_mod4  <= 2'd0;
      pad_remaining   <= 2'd0;
    end else begin
      pixel_format    <= pixel_format_next;
      alpha_present   <= alpha_present_next;
      image_width     <= image_width_next;
      image_height    <= image_height_next;
      palette_last    <= palette_last_next;
      phase           <= phase_next;
      byte_in_item    <= byte_in_item_next;
      held_bytes      <= held_bytes_next;
      palette_counter <= palette_counter_next;
      column          <= column_next;
      row             <= row_next;
      row_bytes_mod4  <= row_bytes_mod4_next;
      pad_remaining   <= pad_remaining_next;
    end
  end

endmodule

// ===== sv/lbpu_queue.sv =====
// Small request queue between the unpacker front and back.
// Register-array FIFO of rec_t entries; depends on lbpu_pkg.
module lbpu_queue #(
  parameter int DEPTH = lbpu_pkg::QUEUE_DEPTH  // 2 or more
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lbpu_pkg::rec_t  push_rec,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output lbpu_pkg::rec_t  head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lbpu_pkg::rec_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/lbpu_back.sv =====
// Back of the unpacker: splits queued requests into color fields.
// Holds the output register of the result stream; depends on lbpu_pkg.
module lbpu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_not_empty,
  input  lbpu_pkg::rec_t  q_head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      item_kind,
  output logic [7:0]      entry_index,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  output logic [7:0]      alpha,
  output logic [15:0]     pixel_x,
  output logic [15:0]     pixel_y,
  output logic            last_pixel
);

  logic [1:0] kind_d;
  logic [7:0] index_d, red_d, green_d, blue_d, alpha_d;

  assign pop = q_not_empty && (!out_valid || out_ready);

  // Field split by item layout
  always_comb begin
    kind_d  = lbpu_pkg::KIND_DIRECT;
    index_d = 8'd0;
    red_d   = q_head.bytes[23:16];
    green_d = q_head.bytes[15:8];
    blue_d  = q_head.bytes[7:0];
    alpha_d = 8'hFF;
    case (q_head.itype)
      lbpu_pkg::IT_PAL3: begin
        kind_d  = lbpu_pkg::KIND_PALETTE;
        index_d = q_head.pal_index;
      end
      lbpu_pkg::IT_PAL4: begin
        kind_d  = lbpu_pkg::KIND_PALETTE;
        index_d = q_head.pal_index;
        red_d   = q_head.bytes[31:24];
        green_d = q_head.bytes[23:16];
        blue_d  = q_head.bytes[15:8];
        alpha_d = q_head.bytes[7:0];
      end
      lbpu_pkg::IT_INDEX: begin
        kind_d  = lbpu_pkg::KIND_INDEX;
        index_d = q_head.bytes[7:0];
        red_d   = 8'd0;
        green_d = 8'd0;
        blue_d  = 8'd0;
        alpha_d = 8'd0;
      end
      lbpu_pkg::IT_RGB15: begin
        // top bit skipped, then 5-bit red, green, blue
        red_d   = {3'd0, q_head.bytes[14:10]};
        green_d = {3'd0, q_head.bytes[9:5]};
        blue_d  = {3'd0, q_head.bytes[4:0]};
      end
      lbpu_pkg::IT_ARGB: begin
        alpha_d = q_head.bytes[31:24];
      end
      default: alpha_d = 8'hFF;
    endcase
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      item_kind   <= kind_d;
      entry_index <= index_d;
      red         <= red_d;
      green       <= green_d;
      blue        <= blue_d;
      alpha       <= alpha_d;
      pixel_x     <= q_head.x;
      pixel_y     <= q_head.y;
      last_pixel  <= q_head.last;
    end
  end

endmodule

// ===== sim/lossless_bitmap_pixel_unpacker_tb.sv =====
// Self-checking bench for the lossless bitmap pixel unpacker.
// Streams bitmap bytes with random gaps and back-pressure and scores every output
// against a behavioral model of the byte parser. Needs lbpu_pkg and the unpacker RTL.
`timescale 1ns / 100ps

module lossless_bitmap_pixel_unpacker_tb;

  localparam int         SETTLE_CYCLES = 8;
  localparam int         RANDOM_BYTES  = 300;
  localparam int         MAX_PRINTED   = 100;

  // One output request as the model predicts it
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  entry;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } unpacked_item_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  // Bytes waiting to go out, and output requests not yet seen
  logic [7:0]     bytes_to_send [$];
  unpacked_item_t items_due [$];
  unpacked_item_t oldest_due;
  int             error_count = 0;

  // Driver and monitor bookkeeping
  logic byte_held  = 1'b0;
  logic send_calm  = 1'b0;
  logic recv_calm  = 1'b0;
  int   send_gap   = 0;
  int   recv_hold  = 0;

  // Model registers
  logic [1:0]  m_fmt;
  logic        m_alpha;
  logic [15:0] m_width;
  logic [15:0] m_height;
  logic [7:0]  m_pal_last;

  // Model parser state
  lbpu_pkg::phase_t st_phase;
  logic [1:0]  st_byte_cnt;
  logic [23:0] st_held;
  logic [7:0]  st_pal_cnt;
  logic [15:0] st_col;
  logic [15:0] st_row;
  logic [1:0]  st_row_mod4;
  logic [1:0]  st_pad;

  lossless_bitmap_pixel_unpacker i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("%0t: %s", $time, msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Pixel phase unless the format or the size leaves nothing to take
  function automatic void enter_pixels();
    if (m_fmt == lbpu_pkg::FMT_UNUSED || m_width == 16'd0 || m_height == 16'd0) begin
      st_phase = lbpu_pkg::PH_DONE;
    end else begin
      st_phase = lbpu_pkg::PH_PIXELS;
    end
  endfunction

  function automatic void restart_stream();
    st_byte_cnt = '0;
    st_held     = '0;
    st_pal_cnt  = '0;
    st_col      = '0;
    st_row      = '0;
    st_row_mod4 = '0;
    st_pad      = '0;
    if (m_fmt == lbpu_pkg::FMT_COLORMAP) begin
      st_phase = lbpu_pkg::PH_PALETTE;
    end else begin
      enter_pixels();
    end
  endfunction

  function automatic void advance_row();
    if (st_row + 32'd1 >= m_height) begin
      st_phase = lbpu_pkg::PH_DONE;
    end else begin
      st_row   = st_row + 16'd1;
      st_phase = lbpu_pkg::PH_PIXELS;
    end
  endfunction

  // Feed one byte to the model; queue the request it completes, if any
  function automatic void unpack_byte(input logic [7:0] b);
    unpacked_item_t r;
    int             need;
    logic [15:0]    w15;
    logic [1:0]     pad;
    r = '0;
    if (st_phase == lbpu_pkg::PH_PAD) begin
      st_pad = st_pad - 2'd1;
      if (st_pad == 2'd0) advance_row();
    end else if (st_phase == lbpu_pkg::PH_PALETTE) begin
      need = m_alpha ? 4 : 3;
      if (st_byte_cnt + 32'd1 < need) begin
        st_held     = {st_held[15:0], b};
        st_byte_cnt = st_byte_cnt + 2'd1;
      end else begin
        r.kind  = lbpu_pkg::KIND_PALETTE;
        r.entry = st_pal_cnt;
        if (m_alpha) begin
          r.red   = st_held[23:16];
          r.green = st_held[15:8];
          r.blue  = st_held[7:0];
          r.alpha = b;
        end else begin
          r.red   = st_held[15:8];
          r.green = st_held[7:0];
          r.blue  = b;
          r.alpha = 8'hFF;
        end
        st_byte_cnt = '0;
        st_held     = '0;
        if (st_pal_cnt == m_pal_last) begin
          st_pal_cnt = '0;
          enter_pixels();
        end else begin
          st_pal_cnt = st_pal_cnt + 8'd1;
        end
        items_due.push_back(r);
      end
    end else if (st_phase == lbpu_pkg::PH_PIXELS) begin
      if (m_fmt == lbpu_pkg::FMT_COLORMAP) need = 1;
      else if (m_fmt == lbpu_pkg::FMT_RGB15) need = 2;
      else need = m_alpha ? 4 : 3;
      st_row_mod4 = st_row_mod4 + 2'd1;
      if (st_byte_cnt + 32'd1 < need) begin
        st_held     = {st_held[15:0], b};
        st_byte_cnt = st_byte_cnt + 2'd1;
      end else begin
        if (m_fmt == lbpu_pkg::FMT_COLORMAP) begin
          r.kind  = lbpu_pkg::KIND_INDEX;
          r.entry = b;
        end else if (m_fmt == lbpu_pkg::FMT_RGB15) begin
          // top bit of the 16-bit word is skipped
          w15     = {st_held[7:0], b};
          r.kind  = lbpu_pkg::KIND_DIRECT;
          r.red   = 8'(w15[14:10]);
          r.green = 8'(w15[9:5]);
          r.blue  = 8'(w15[4:0]);
          r.alpha = 8'hFF;
        end else if (m_alpha) begin
          r.kind  = lbpu_pkg::KIND_DIRECT;
          r.alpha = st_held[23:16];
          r.red   = st_held[15:8];
          r.green = st_held[7:0];
          r.blue  = b;
        end else begin
          r.kind  = lbpu_pkg::KIND_DIRECT;
          r.red   = st_held[15:8];
          r.green = st_held[7:0];
          r.blue  = b;
          r.alpha = 8'hFF;
        end
        r.x    = st_col;
        r.y    = st_row;
        r.last = (st_col + 32'd1 == m_width) && (st_row + 32'd1 == m_height);
        st_byte_cnt = '0;
        st_held     = '0;
        // end of row: swallow padding up to a multiple of four bytes
        if (st_col + 32'd1 >= m_width) begin
          pad         = 2'd0 - st_row_mod4;
          st_col      = '0;
          st_row_mod4 = '0;
          if (pad != 2'd0) begin
            st_pad   = pad;
            st_phase = lbpu_pkg::PH_PAD;
          end else begin
            advance_row();
          end
        end else begin
          st_col = st_col + 16'd1;
        end
        items_due.push_back(r);
      end
    end
  endfunction

  // One register write; every valid index restarts the stream
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      lbpu_pkg::REG_PIXEL_FORMAT:  m_fmt      = data[1:0];
      lbpu_pkg::REG_ALPHA_PRESENT: m_alpha    = data[0];
      lbpu_pkg::REG_IMAGE_WIDTH:   m_width    = data;
      lbpu_pkg::REG_IMAGE_HEIGHT:  m_height   = data;
      lbpu_pkg::REG_PALETTE_LAST:  m_pal_last = data[7:0];
      default: ;
    endcase
    if (idx <= lbpu_pkg::REG_PALETTE_LAST) restart_stream();
  endtask

  // Write all registers in random order, with junk in unused upper bits now and then
  task automatic load_config(input logic [1:0] fmt, input logic alpha,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] pal);
    logic [2:0]  order [5];
    logic [2:0]  t;
    logic [15:0] junk;
    int          i;
    int          j;
    for (i = 0; i < 5; i++) order[i] = 3'(i);
    for (i = 4; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < 5; i++) begin
      junk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
      case (order[i])
        lbpu_pkg::REG_PIXEL_FORMAT:
          write_reg(lbpu_pkg::REG_PIXEL_FORMAT, {junk[15:2], fmt});
        lbpu_pkg::REG_ALPHA_PRESENT:
          write_reg(lbpu_pkg::REG_ALPHA_PRESENT, {junk[15:1], alpha});
        lbpu_pkg::REG_IMAGE_WIDTH:  write_reg(lbpu_pkg::REG_IMAGE_WIDTH, w);
        lbpu_pkg::REG_IMAGE_HEIGHT: write_reg(lbpu_pkg::REG_IMAGE_HEIGHT, h);
        default: write_reg(lbpu_pkg::REG_PALETTE_LAST, {junk[15:8], pal});
      endcase
      // writes to unmapped indexes must change nothing
      if ($urandom_range(0, 7) == 0) write_reg(3'($urandom_range(5, 7)), 16'($urandom));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every byte is taken and every predicted request has arrived
  task automatic drain();
    while (bytes_to_send.size() != 0 || byte_held || items_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Drain, then wait so that any request the model did not predict shows up
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Byte driver: one byte held at a time, random gap between bytes unless send_calm
  always @(posedge clk) begin
    if (rst) begin
      byte_held = 1'b0;
      send_gap  = 0;
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        unpack_byte(s_tdata);
        byte_held = 1'b0;
      end
      if (!byte_held && send_gap > 0) begin
        send_gap--;
      end else if (!byte_held && bytes_to_send.size() != 0) begin
        s_tdata  <= bytes_to_send.pop_front();
        byte_held = 1'b1;
        send_gap  = send_calm ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 31) == 0) send_calm = ~send_calm;
      end
      s_tvalid <= byte_held;
    end
  end

  // Result monitor: score accepted requests; random stalls after each unless recv_calm
  always @(posedge clk) begin
    if (rst) begin
      recv_hold = 0;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (items_due.size() == 0) begin
          report_mismatch("output request with nothing expected");
        end else begin
          oldest_due = items_due.pop_front();
          check_field("item_kind", 16'(m_tuser), 16'(oldest_due.kind));
          check_field("entry_index", 16'(m_tdata[7:0]), 16'(oldest_due.entry));
          check_field("red", 16'(m_tdata[15:8]), 16'(oldest_due.red));
          check_field("green", 16'(m_tdata[23:16]), 16'(oldest_due.green));
          check_field("blue", 16'(m_tdata[31:24]), 16'(oldest_due.blue));
          check_field("alpha", 16'(m_tdata[39:32]), 16'(oldest_due.alpha));
          check_field("pixel_x", m_tdata[55:40], oldest_due.x);
          check_field("pixel_y", m_tdata[71:56], oldest_due.y);
          check_field("last_pixel", 16'(m_tlast), 16'(oldest_due.last));
        end
        recv_hold = recv_calm ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 31) == 0) recv_calm = ~recv_calm;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    logic [1:0]  fmt;
    logic        alpha;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  pal;
    longint      row_len;
    longint      len;
    int          bpp;
    int          n;
    int          extra;
    int          pause_at;
    int          sel;
    int          counted;
    logic        paused;
    int          i;

    m_fmt      = lbpu_pkg::RST_PIXEL_FORMAT;
    m_alpha    = lbpu_pkg::RST_ALPHA_PRESENT;
    m_width    = lbpu_pkg::RST_IMAGE_WIDTH;
    m_height   = lbpu_pkg::RST_IMAGE_HEIGHT;
    m_pal_last = lbpu_pkg::RST_PALETTE_LAST;
    restart_stream();
    counted = 0;
    paused  = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: 1x1 RGB24, one pad byte, then a byte after the image
    bytes_to_send.push_back(8'h00); bytes_to_send.push_back(8'hFF);
    bytes_to_send.push_back(8'h80); bytes_to_send.push_back(8'hAA);
    bytes_to_send.push_back(8'h55);
    settle();

    // Colormap with alpha: one RGBA entry, one index, three pad bytes
    load_config(lbpu_pkg::FMT_COLORMAP, 1'b1, 16'd1, 16'd1, 8'd0);
    bytes_to_send.push_back(8'hFF); bytes_to_send.push_back(8'h00);
    bytes_to_send.push_back(8'hAA); bytes_to_send.push_back(8'h55);
    bytes_to_send.push_back(8'h7F); bytes_to_send.push_back(8'h01);
    bytes_to_send.push_back(8'h02); bytes_to_send.push_back(8'h03);
    settle();

    // RGB15: all ones, then only the skipped top bit set
    load_config(lbpu_pkg::FMT_RGB15, 1'b0, 16'd2, 16'd1, 8'd0);
    bytes_to_send.push_back(8'hFF); bytes_to_send.push_back(8'hFF);
    bytes_to_send.push_back(8'h80); bytes_to_send.push_back(8'h00);
    settle();

    // RGB24 with alpha first
    load_config(lbpu_pkg::FMT_RGB24, 1'b1, 16'd1, 16'd1, 8'd0);
    bytes_to_send.push_back(8'h12); bytes_to_send.push_back(8'h34);
    bytes_to_send.push_back(8'h56); bytes_to_send.push_back(8'h78);
    settle();

    // Unused format takes nothing
    load_config(lbpu_pkg::FMT_UNUSED, 1'b0, 16'd1, 16'd1, 8'd0);
    bytes_to_send.push_back(8'hC3); bytes_to_send.push_back(8'h3C);
    settle();

    // Zero width: palette is still taken, pixels are not
    load_config(lbpu_pkg::FMT_COLORMAP, 1'b0, 16'd0, 16'd1, 8'd0);
    bytes_to_send.push_back(8'h01); bytes_to_send.push_back(8'hFE);
    bytes_to_send.push_back(8'h80); bytes_to_send.push_back(8'h7F);
    settle();

    // Largest palette
    load_config(lbpu_pkg::FMT_COLORMAP, 1'b0, 16'd1, 16'd1, 8'd255);
    repeat (256 * 3 + 4) bytes_to_send.push_back(8'($urandom));
    settle();

    // Random images: mostly complete streams, some cut short, some with trailing noise
    while (counted < RANDOM_BYTES) begin
      sel   = $urandom_range(0, 12);
      fmt   = (sel == 12) ? lbpu_pkg::FMT_UNUSED : 2'(sel % 3);
      alpha = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 15))
        0:       w = 16'd0;
        1:       w = 16'hFFFF;
        default: w = 16'($urandom_range(1, 9));
      endcase
      case ($urandom_range(0, 15))
        0:       h = 16'd0;
        1:       h = 16'hFFFF;
        default: h = 16'($urandom_range(1, 4));
      endcase
      pal = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(16, 40))
                                        : 8'($urandom_range(0, 15));
      load_config(fmt, alpha, w, h, pal);

      if (fmt == lbpu_pkg::FMT_COLORMAP) bpp = 1;
      else if (fmt == lbpu_pkg::FMT_RGB15) bpp = 2;
      else bpp = alpha ? 4 : 3;
      row_len = ((longint'(w) * bpp + 3) / 4) * 4;
      len = (fmt == lbpu_pkg::FMT_COLORMAP) ? (longint'(pal) + 1) * (alpha ? 4 : 3) : 0;
      if (fmt != lbpu_pkg::FMT_UNUSED && w != 16'd0 && h != 16'd0) begin
        len += longint'(h) * row_len;
      end

      // huge images are only started, never finished
      n = (len > 400) ? $urandom_range(10, 60) : int'(len);
      if (n > 1 && $urandom_range(0, 9) == 0) n = $urandom_range(1, n - 1);
      extra    = (len == 0 || $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
      pause_at = (!paused && n >= 8) ? n / 2 : -1;

      for (i = 0; i < n; i++) begin
        // hold the sender once until every request so far has come out
        if (i == pause_at) begin
          drain();
          paused = 1'b1;
        end
        bytes_to_send.push_back(8'($urandom));
      end
      counted += n;
      repeat (extra) bytes_to_send.push_back(8'($urandom));
      settle();
    end

    if (error_count == 0) begin
      $display("[lossless_bitmap_pixel_unpacker] OK");
    end else begin
      $display("[lossless_bitmap_pixel_unpacker] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("[lossless_bitmap_pixel_unpacker] ERROR");
    $finish;
  end

endmodule
